FILE: rtl/tsnm_pkg.sv
`default_nettype none

package tsnm_pkg;

  // Fixed geometry of a teletext page header.
  localparam int HDR_LEN = 24;
  localparam int HDR_IDX_W = 5;
  localparam logic [HDR_IDX_W-1:0] HDR_LAST = HDR_IDX_W'(HDR_LEN - 1);

  // Default table geometry.
  localparam int NUM_STATIONS_DEF = 16;
  localparam int NAME_CHARS_DEF = 24;

  // Field and register widths fixed by the interface.
  localparam int CMD_W = 2;
  localparam int CHAR_W = 7;
  localparam int COUNT_W = 5;
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;

  // Reset value of the station count register.
  localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(1);

  // Register index carried by the APB address.
  localparam logic REG_STATION_COUNT = 1'b0;

  // Command codes of the input channel.
  localparam logic [CMD_W-1:0] CMD_NAME_CHAR = 2'd0;
  localparam logic [CMD_W-1:0] CMD_NAME_LEN  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_HDR_BYTE  = 2'd2;

  // Wildcard character in the cleaned header.
  localparam logic [CHAR_W-1:0] WILDCARD = '0;

  // Odd-parity check and removal of national-charset codes.
  function automatic logic [CHAR_W-1:0] clean_byte(input logic [7:0] b);
    logic [CHAR_W-1:0] c;
    c = b[CHAR_W-1:0];
    if (!(^b)) begin
      return WILDCARD;
    end
    if (c inside {7'h23, 7'h24, 7'h40, [7'h5b:7'h60], [7'h7b:7'h7e]}) begin
      return WILDCARD;
    end
    return c;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/teletext_station_name_match_unit.sv
// After the 24th header byte, the unit walks the name of each station tried in turn (a
// walk ends early once no offset can still match), then posts the result from S_DONE.
// Throughput: name and length writes and the first 23 header bytes are accepted one per
// cycle while idle; the input stalls while the table walk runs, one name character per
// cycle, and until the result register is free. Reset: station count returns to 1, name
// lengths read as zero, header index clears.
`default_nettype none

module teletext_station_name_match_unit
  import tsnm_pkg::*;
#(
  parameter int NUM_STATIONS = NUM_STATIONS_DEF,
  parameter int NAME_CHARS = NAME_CHARS_DEF
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,

  // APB configuration port
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [APB_AW-1:0]   paddr,
  input  wire logic [APB_DW-1:0]   pwdata,
  output logic      [APB_DW-1:0]   prdata,
  output logic                     pready,

  // Input channel
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic [CMD_W-1:0]    command_i,
  input  wire logic [3:0]          station_i,
  input  wire logic [4:0]          position_i,
  input  wire logic [CHAR_W-1:0]   char_value_i,
  input  wire logic [4:0]          name_length_i,
  input  wire logic [7:0]          header_byte_i,
  input  wire logic [3:0]          hint_i,

  // Output channel
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic [3:0]               matched_station_o
);

  localparam int ST_W = (NUM_STATIONS > 1) ? $clog2(NUM_STATIONS) : 1;
  localparam int CNT_W = $clog2(NUM_STATIONS + 1);
  localparam int CHAR_AW = (NAME_CHARS > 1) ? $clog2(NAME_CHARS) : 1;
  localparam int LEN_W = $clog2(NAME_CHARS + 1);
  localparam int NAME_DEPTH = NUM_STATIONS * (2 ** CHAR_AW);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_ISSUE = 2'd1;
  localparam logic [1:0] S_WALK  = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  // Configuration register.
  logic [COUNT_W-1:0] station_count_q;
  logic               cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_STATION_COUNT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      station_count_q <= COUNT_RESET;
    end else if (cfg_wr) begin
      station_count_q <= pwdata[COUNT_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_STATION_COUNT) begin
      prdata = APB_DW'(station_count_q);
    end
  end

  // Control state.
  logic [1:0]           state_q, state_d;
  logic [HDR_IDX_W-1:0] hdr_idx_q;
  logic [CNT_W-1:0]     cur_q, cur_d;
  logic [CNT_W-1:0]     hint_q;
  logic                 hint_vld_q;
  logic                 hint_phase_q, hint_phase_d;
  logic [LEN_W-1:0]     k_q, k_d;
  logic [HDR_LEN-1:0]   d_q, d_d;
  logic [3:0]           res_q, res_d;
  logic                 out_valid_q;
  logic [3:0]           out_data_q;

  // Header characters after cleaning.
  logic [CHAR_W-1:0]    hdr_q [HDR_LEN];

  // Input transaction decode.
  logic in_acc;
  logic wr_char, wr_len, wr_hdr, hdr_last;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign wr_char    = in_acc && (command_i == CMD_NAME_CHAR)
                      && (int'(station_i) < NUM_STATIONS)
                      && (int'(position_i) < NAME_CHARS);
  assign wr_len     = in_acc && (command_i == CMD_NAME_LEN)
                      && (int'(station_i) < NUM_STATIONS);
  assign wr_hdr     = in_acc && (command_i == CMD_HDR_BYTE);
  assign hdr_last   = wr_hdr && (hdr_idx_q == HDR_LAST);

  // Effective station count and hint check.
  logic [CNT_W-1:0] cnt;
  logic             hint_ok;

  assign cnt = (int'(station_count_q) > NUM_STATIONS) ? CNT_W'(NUM_STATIONS)
                                                     : CNT_W'(station_count_q);
  assign hint_ok = (hint_i != '0) && (int'(hint_i) < int'(cnt));

  // Name memory, one padded row per station.
  logic [CHAR_W-1:0]         name_mem [NAME_DEPTH];
  logic [CHAR_W-1:0]         name_rd_q;
  logic [ST_W+CHAR_AW-1:0]   name_waddr, name_raddr;
  logic [LEN_W-1:0]          k_inc;

  assign k_inc      = k_q + LEN_W'(1);
  assign name_waddr = {ST_W'(station_i), CHAR_AW'(position_i)};
  assign name_raddr = {cur_q[ST_W-1:0],
                       (state_q == S_WALK) ? k_inc[CHAR_AW-1:0] : CHAR_AW'(0)};

  always_ff @(posedge clk_i) begin
    if (wr_char) begin
      name_mem[name_waddr] <= char_value_i;
    end
    name_rd_q <= name_mem[name_raddr];
  end

  // Length memory with per-entry valid bits; an invalid entry reads as zero.
  logic [LEN_W-1:0]        len_mem [NUM_STATIONS];
  logic [LEN_W-1:0]        len_rd_q;
  logic [NUM_STATIONS-1:0] len_vld_q;
  logic                    len_vld_rd_q;
  logic [LEN_W-1:0]        len_wdata;
  logic [LEN_W-1:0]        len_eff;

  assign len_wdata = (int'(name_length_i) > NAME_CHARS) ? LEN_W'(NAME_CHARS)
                                                       : LEN_W'(name_length_i);
  assign len_eff   = len_vld_rd_q ? len_rd_q : '0;

  always_ff @(posedge clk_i) begin
    if (wr_len) begin
      len_mem[ST_W'(station_i)] <= len_wdata;
    end
    len_rd_q <= len_mem[cur_q[ST_W-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_vld_q    <= '0;
      len_vld_rd_q <= 1'b0;
    end else begin
      if (wr_len) begin
        len_vld_q[ST_W'(station_i)] <= 1'b1;
      end
      len_vld_rd_q <= len_vld_q[cur_q[ST_W-1:0]];
    end
  end

  // Header capture.
  always_ff @(posedge clk_i) begin
    if (wr_hdr) begin
      hdr_q[hdr_idx_q] <= clean_byte(header_byte_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_idx_q <= '0;
    end else if (wr_hdr) begin
      hdr_idx_q <= hdr_last ? '0 : hdr_idx_q + HDR_IDX_W'(1);
    end
  end

  // Per-position compare of the current name character against the header.
  logic [HDR_LEN-1:0] eq;

  always_comb begin
    for (int j = 0; j < HDR_LEN; j++) begin
      eq[j] = (hdr_q[j] == WILDCARD) || (hdr_q[j] == name_rd_q);
    end
  end

  // Walk control: candidate end positions advance one name character per cycle.
  logic             stop;
  logic             match;
  logic [CNT_W-1:0] next_base, next_st;

  assign stop      = (k_q >= len_eff) || (name_rd_q == WILDCARD) || (d_q == '0);
  assign match     = |d_q;
  assign next_base = hint_phase_q ? CNT_W'(1) : cur_q + CNT_W'(1);
  assign next_st   = (hint_vld_q && (next_base == hint_q)) ? next_base + CNT_W'(1)
                                                           : next_base;

  always_comb begin
    state_d      = state_q;
    cur_d        = cur_q;
    hint_phase_d = hint_phase_q;
    k_d          = k_q;
    d_d          = d_q;
    res_d        = res_q;
    case (state_q)
      S_IDLE: begin
        if (hdr_last) begin
          if (hint_ok) begin
            cur_d        = CNT_W'(hint_i);
            hint_phase_d = 1'b1;
            state_d      = S_ISSUE;
          end else if (cnt > CNT_W'(1)) begin
            cur_d        = CNT_W'(1);
            hint_phase_d = 1'b0;
            state_d      = S_ISSUE;
          end else begin
            res_d   = '0;
            state_d = S_DONE;
          end
        end
      end
      S_ISSUE: begin
        k_d     = '0;
        d_d     = '1;
        state_d = S_WALK;
      end
      S_WALK: begin
        if (!stop) begin
          d_d = {d_q[HDR_LEN-2:0], (k_q == '0)} & eq;
          k_d = k_inc;
        end else if (match) begin
          res_d   = 4'(cur_q);
          state_d = S_DONE;
        end else if (next_st >= cnt) begin
          res_d   = '0;
          state_d = S_DONE;
        end else begin
          cur_d        = next_st;
          hint_phase_d = 1'b0;
          state_d      = S_ISSUE;
        end
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      cur_q        <= '0;
      hint_phase_q <= 1'b0;
      hint_vld_q   <= 1'b0;
      hint_q       <= '0;
      k_q          <= '0;
    end else begin
      state_q      <= state_d;
      cur_q        <= cur_d;
      hint_phase_q <= hint_phase_d;
      k_q          <= k_d;
      if (hdr_last) begin
        hint_vld_q <= hint_ok;
        hint_q     <= CNT_W'(hint_i);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    d_q   <= d_d;
    res_q <= res_d;
  end

  // Output register: holds a result until the consumer takes the transaction.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((state_q == S_DONE) && (!out_valid_q || !out_stall_i)) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == S_DONE) && (!out_valid_q || !out_stall_i)) begin
      out_data_q <= res_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign matched_station_o = out_data_q;

endmodule

`default_nettype wire
